// ===== rtl/mdl_pkg.sv =====
// ----------------------------------------------------------------------------
// Modulated delay line package
// Shared widths, constants and the back-end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mdl_pkg;

  // Fixed field widths of the sample and offset formats
  localparam int SAMPLE_BITS = 24;                          // Q1.23 samples
  localparam int FRAC_BITS   = 8;                           // fraction bits of the offset
  localparam int OFFSET_BITS = 21;                          // Q12.8 signed offset
  localparam int IP_BITS     = OFFSET_BITS - 1 - FRAC_BITS; // integer part of the offset
  localparam int LEN_BITS    = 12;                          // delay length register

  // Channel stores
  localparam int CHANNELS = 2;
  localparam int CH_BITS  = 1;

  // Default store depth per channel
  localparam int DEPTH_DEF = 4096;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Back-end sequencer: store clearing, first tap read, second tap read and write
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_READ0,
    BK_READ1
  } mdl_back_state_t;

endpackage

`default_nettype wire

// ===== rtl/mdl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data (old data on a
// same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module mdl_ram #(
  parameter int WIDTH = 24,
  parameter int WORDS = 8192,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/mdl_fifo.sv =====
// ----------------------------------------------------------------------------
// Modulated delay line queue
// Short register queue that decouples the address front end from the
// memory back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mdl_fifo
  import mdl_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mdl_front.sv =====
// ----------------------------------------------------------------------------
// Modulated delay line front end
// Accepts transactions, clamps the offset and works out both tap positions
// and the write position in a three-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mdl_front
  import mdl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int QW = CH_BITS + SAMPLE_BITS + FRAC_BITS + 3 * AW
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          hold,
  input  wire logic        [LEN_BITS-1:0]    delay_length,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic        [CH_BITS-1:0]     channel,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic signed [OFFSET_BITS-1:0] mod_offset,
  input  wire logic                          end_of_frame,
  output logic                               q_valid,
  input  wire logic                          q_ready,
  output logic             [QW-1:0]          q_data
);

  localparam int XW = ((AW > LEN_BITS) ? AW : LEN_BITS) + 2;
  localparam int RS = 2 * IP_BITS;
  localparam int PW = IP_BITS + RS;
  localparam int MW = IP_BITS + AW + 1;
  localparam logic [RS-1:0] RECIP    = RS'((64'd1 << RS) / DEPTH);
  localparam logic [XW-1:0] DEPTH_X  = XW'(DEPTH);
  localparam logic [MW-1:0] DEPTH_M  = MW'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  logic accept;
  logic s1_move;
  logic s2_move;
  logic s3_move;

  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;

  // stage 1: quotient estimate and base position
  logic                   s1_valid;
  logic [CH_BITS-1:0]     s1_ch;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [FRAC_BITS-1:0]   s1_frac;
  logic [IP_BITS-1:0]     s1_ip;
  logic [IP_BITS-1:0]     s1_q;
  logic [AW-1:0]          s1_base;
  logic [AW-1:0]          s1_wpos;

  // stage 2: integer part reduced modulo the depth
  logic                   s2_valid;
  logic [CH_BITS-1:0]     s2_ch;
  logic [SAMPLE_BITS-1:0] s2_sample;
  logic [FRAC_BITS-1:0]   s2_frac;
  logic [AW-1:0]          s2_rem;
  logic [AW-1:0]          s2_base;
  logic [AW-1:0]          s2_wpos;

  // stage 3: packed queue entry
  logic          s3_valid;
  logic [QW-1:0] s3_data;

  logic [OFFSET_BITS-2:0] offs_mag;
  logic [IP_BITS-1:0]     ip;
  logic [FRAC_BITS-1:0]   frac;
  logic [PW-1:0]          q_prod;
  logic [XW-1:0]          base_diff;
  logic [XW-1:0]          base_wrap;
  logic [MW-1:0]          qd;
  logic [MW-1:0]          rem_a;
  logic [MW-1:0]          rem_b;
  logic [XW-1:0]          tap_diff;
  logic [XW-1:0]          tap_wrap;
  logic [AW-1:0]          i0;
  logic [AW-1:0]          i1;

  assign s3_move  = s3_valid && q_ready;
  assign s2_move  = s2_valid && (!s3_valid || s3_move);
  assign s1_move  = s1_valid && (!s2_valid || s2_move);
  assign in_ready = !hold && (!s1_valid || s1_move);
  assign accept   = in_valid && in_ready;

  assign q_valid = s3_valid;
  assign q_data  = s3_data;

  always_comb begin
    // negative offset counts as zero delay
    offs_mag = mod_offset[OFFSET_BITS-1] ? '0 : mod_offset[OFFSET_BITS-2:0];
    ip       = offs_mag[OFFSET_BITS-2:FRAC_BITS];
    frac     = offs_mag[FRAC_BITS-1:0];
    // quotient by reciprocal, at most one low
    q_prod   = {{RS{1'b0}}, ip} * {{IP_BITS{1'b0}}, RECIP};
    base_diff = XW'(wp) - XW'(delay_length);
    base_wrap = base_diff[XW-1] ? base_diff + DEPTH_X : base_diff;
    wp_next   = (wp == LAST_POS) ? '0 : wp + AW'(1);

    qd    = MW'(s1_q) * DEPTH_M;
    rem_a = MW'(s1_ip) - qd;
    rem_b = (rem_a >= DEPTH_M) ? rem_a - DEPTH_M : rem_a;

    tap_diff = XW'(s2_base) - XW'(s2_rem);
    tap_wrap = tap_diff[XW-1] ? tap_diff + DEPTH_X : tap_diff;
    i0       = tap_wrap[AW-1:0];
    i1       = (i0 == '0) ? LAST_POS : i0 - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (accept && end_of_frame) begin
        wp <= wp_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        s3_valid <= 1'b1;
      end else if (s3_move) begin
        s3_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch     <= channel;
      s1_sample <= sample_in;
      s1_frac   <= frac;
      s1_ip     <= ip;
      s1_q      <= q_prod[PW-1:RS];
      s1_base   <= base_wrap[AW-1:0];
      s1_wpos   <= wp;
    end
    if (s1_move) begin
      s2_ch     <= s1_ch;
      s2_sample <= s1_sample;
      s2_frac   <= s1_frac;
      s2_rem    <= rem_b[AW-1:0];
      s2_base   <= s1_base;
      s2_wpos   <= s1_wpos;
    end
    if (s2_move) begin
      s3_data <= {s2_ch, s2_sample, s2_frac, i0, i1, s2_wpos};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mdl_back.sv =====
// ----------------------------------------------------------------------------
// Modulated delay line back end
// Clears the store after reset, reads both taps, writes the new sample,
// interpolates and holds results in a two-deep output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mdl_back
  import mdl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int QW = CH_BITS + SAMPLE_BITS + FRAC_BITS + 3 * AW
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire logic        [QW-1:0]          q_data,
  output logic                               clearing,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic             [CH_BITS-1:0]     out_channel,
  output logic signed      [SAMPLE_BITS-1:0] delayed_sample
);

  localparam int RAW   = CH_BITS + AW;
  localparam int WORDS = CHANNELS << AW;
  localparam int ACW   = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic [SAMPLE_BITS-1:0] SIGN_MASK = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [ACW-1:0]         HALF      = ACW'(1) << (FRAC_BITS - 1);

  mdl_back_state_t state;
  mdl_back_state_t state_next;

  logic [CH_BITS-1:0]     h_ch;
  logic [SAMPLE_BITS-1:0] h_sample;
  logic [FRAC_BITS-1:0]   h_frac;
  logic [AW-1:0]          h_i0;
  logic [AW-1:0]          h_i1;
  logic [AW-1:0]          h_wpos;

  logic [RAW-1:0]         clr_addr;
  logic                   ram_we;
  logic [RAW-1:0]         ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [RAW-1:0]         ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic                   c_valid;
  logic [CH_BITS-1:0]     c_ch;
  logic [FRAC_BITS-1:0]   c_frac;
  logic [SAMPLE_BITS-1:0] r0;

  logic                   pend_valid;
  logic [CH_BITS-1:0]     pend_ch;
  logic [SAMPLE_BITS-1:0] pend_sample;
  logic                   pend_move;
  logic                   take;
  logic [1:0]             occ;
  logic [1:0]             occ_after;
  logic                   slot_free;

  logic [SAMPLE_BITS-1:0]      u0;
  logic [SAMPLE_BITS-1:0]      u1;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [FRAC_BITS:0]   weight;
  logic signed [ACW-1:0]       prod;
  logic [ACW-1:0]              acc;
  logic [SAMPLE_BITS-1:0]      res;

  assign {h_ch, h_sample, h_frac, h_i0, h_i1, h_wpos} = q_data;

  mdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .WORDS (WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // results in flight, waiting and shown; start only when one slot stays free
  assign take      = out_valid && out_ready;
  assign occ       = 2'(out_valid) + 2'(pend_valid) + 2'(c_valid);
  assign occ_after = occ - 2'(take);
  assign slot_free = (occ_after != 2'd2);
  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign clearing  = (state == BK_CLEAR);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = {h_ch, h_wpos};
    ram_wdata  = h_sample;
    ram_raddr  = {h_ch, h_i0};
    q_ready    = 1'b0;
    case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == '1) begin
          state_next = BK_READ0;
        end
      end
      BK_READ0: begin
        if (q_valid && slot_free) begin
          state_next = BK_READ1;
        end
      end
      BK_READ1: begin
        // older tap read and new sample written in the same cycle: read sees old data
        ram_raddr  = {h_ch, h_i1};
        ram_we     = 1'b1;
        q_ready    = 1'b1;
        state_next = BK_READ0;
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    u0     = r0 ^ SIGN_MASK;
    u1     = ram_rdata ^ SIGN_MASK;
    diff   = $signed({1'b0, u1}) - $signed({1'b0, u0});
    weight = $signed({1'b0, c_frac});
    prod   = ACW'(diff) * ACW'(weight);
    acc    = {2'b00, u0, {FRAC_BITS{1'b0}}} + prod + HALF;
    res    = acc[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS] ^ SIGN_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_CLEAR;
      clr_addr   <= '0;
      c_valid    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      c_valid <= (state == BK_READ1);
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + RAW'(1);
      end
      if (c_valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ1) begin
      r0     <= ram_rdata;
      c_ch   <= h_ch;
      c_frac <= h_frac;
    end
    if (c_valid) begin
      pend_ch     <= c_ch;
      pend_sample <= res;
    end
    if (pend_move) begin
      out_channel    <= pend_ch;
      delayed_sample <= pend_sample;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/modulated_delay_line.sv =====
// ----------------------------------------------------------------------------
// Modulated delay line
// Multichannel circular delay with a fractional, modulated tap and linear
// interpolation between the two neighbouring samples.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload
//  --------  -----------------------  -------------------------------------------
//  config    cfg_write                cfg_data (delay length, clamped 1..LEN_MAX)
//  input     in_valid / in_ready      channel, sample_in, mod_offset, end_of_frame
//  output    out_valid / out_ready    out_channel, delayed_sample
//
//  The store has a single read port, so the two taps of a transaction are read
//  on consecutive cycles, and the back end takes the next one only after both.
//  After reset the store is cleared one word a cycle, all CHANNELS * 2^ceil(log2
//  DEPTH) words (8192 at defaults), with in_ready held low meanwhile.
//  A stalled output fills the two result slots, then the queue and the
//  front pipeline, before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module modulated_delay_line
  import mdl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic        [LEN_BITS-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic        [CH_BITS-1:0]     channel,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic signed [OFFSET_BITS-1:0] mod_offset,
  input  wire logic                          end_of_frame,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic             [CH_BITS-1:0]     out_channel,
  output logic signed      [SAMPLE_BITS-1:0] delayed_sample
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW = CH_BITS + SAMPLE_BITS + FRAC_BITS + 3 * AW;
  // largest delay the register can hold for this depth
  localparam logic [LEN_BITS-1:0] LEN_MAX =
    LEN_BITS'(((DEPTH - 1) > ((1 << LEN_BITS) - 1)) ? ((1 << LEN_BITS) - 1) : (DEPTH - 1));

  logic [LEN_BITS-1:0] delay_length;
  logic [LEN_BITS-1:0] delay_length_next;
  logic                clearing;

  // front end to queue
  logic          f_valid;
  logic          f_ready;
  logic [QW-1:0] f_data;

  // queue to back end
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;

  // Clamp the written delay into range: zero becomes one, too large becomes the maximum.
  always_comb begin
    if (cfg_data > LEN_MAX) begin
      delay_length_next = LEN_MAX;
    end else if (cfg_data == '0) begin
      delay_length_next = LEN_BITS'(1);
    end else begin
      delay_length_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= LEN_BITS'(1);
    end else if (cfg_write) begin
      delay_length <= delay_length_next;
    end
  end

  // Front: accept, clamp the offset, work out both tap positions and the write position.
  mdl_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (clearing),
    .delay_length (delay_length),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .channel      (channel),
    .sample_in    (sample_in),
    .mod_offset   (mod_offset),
    .end_of_frame (end_of_frame),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_data       (f_data)
  );

  // Queue: let the front keep accepting while the back waits on the output.
  mdl_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Back: read both taps, write the new sample, interpolate, hold the result.
  mdl_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_data         (q_data),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .delayed_sample (delayed_sample)
  );

  // No transaction may enter while the store is still being cleared.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(in_valid && in_ready))
    else $error("input accepted during store clearing");

  // The clearing pass always follows reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> clearing)
    else $error("store clearing not started after reset");

  // Delay register stays within one to the depth limit.
  a_delay_in_range: assert property (@(posedge clk) disable iff (rst)
    (delay_length != '0) && (delay_length <= LEN_MAX))
    else $error("delay length out of range");

  // The back end only takes an entry the queue actually holds.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> q_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire
